// File: design/rfpa_pkg.sv
// ----------------------------------------------------------------------------
// rfpa_pkg
// Shared types and constants for the range frame parser and averager.
// ----------------------------------------------------------------------------
package rfpa_pkg;

    localparam logic [7:0] SYNC_A    = 8'hEB;
    localparam logic [7:0] SYNC_B    = 8'h90;
    localparam logic [7:0] STATUS_OK = 8'h01;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int DIST_W  = 16;
    // Quotient times ten needs four more bits than the quotient.
    localparam int PROD_W  = SUM_W + 4;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Frame parser states.
    typedef enum logic [2:0] {
        PS_IDLE   = 3'd0,
        PS_SYNC_A = 3'd1,
        PS_SYNC_B = 3'd2,
        PS_STATUS = 3'd3,
        PS_LOW    = 3'd4,
        PS_HIGH   = 3'd5,
        PS_CHECK  = 3'd6,
        PS_END    = 3'd7
    } t_parse_state;

    // Controller states.
    typedef enum logic [1:0] {
        C_IDLE = 2'd0,
        C_DIV  = 2'd1,
        C_LOAD = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic take_byte;
        logic start_div;
        logic step_div;
        logic load_out;
    } t_dp_cmd;

endpackage

// File: design/rfpa_ctrl.sv
// ----------------------------------------------------------------------------
// rfpa_ctrl
// Handshake control and sequencing of the averaging division.
// ----------------------------------------------------------------------------
module rfpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_command,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rfpa_pkg::t_dp_cmd o_cmd
);
    import rfpa_pkg::*;

    t_ctrl_state       r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == C_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        // A waiting result leaves once the consumer takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            C_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_READ) begin
                        o_cmd.start_div = 1'b1;
                        n_step          = '0;
                        n_state         = C_DIV;
                    end else begin
                        o_cmd.take_byte = 1'b1;
                    end
                end
            end
            C_DIV: begin
                o_cmd.step_div = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = C_LOAD;
                end
            end
            C_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

endmodule

// File: design/rfpa_dp.sv
// ----------------------------------------------------------------------------
// rfpa_dp
// Frame parser, accumulators, restoring divider and output register.
// ----------------------------------------------------------------------------
module rfpa_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rfpa_pkg::t_dp_cmd           i_cmd,
    input  logic [7:0]                  i_rx_byte,
    output logic [rfpa_pkg::DIST_W-1:0] o_avg_range,
    output logic                        o_reading_valid
);
    import rfpa_pkg::*;

    t_parse_state      r_parse, n_parse;
    logic [7:0]        r_low, r_high, r_check;
    logic [DIST_W-1:0] r_frame_value;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;

    logic [SUM_W-1:0]  r_quot;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_divisor;
    logic              r_nonzero;

    logic [DIST_W-1:0] r_dist;
    logic              r_rd_valid;

    logic [7:0]        check_sum;
    logic              check_good;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              rem_ge;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] dist_sat;

    // Frame check: the byte sum including the checksum is zero modulo 256.
    assign check_sum  = STATUS_OK + r_low + r_high + SYNC_A + SYNC_B + r_check;
    assign check_good = (check_sum == 8'h00);

    always_comb begin
        n_parse = r_parse;
        unique case (r_parse)
            PS_IDLE:   if (i_rx_byte == SYNC_A) n_parse = PS_SYNC_A;
            PS_SYNC_A: n_parse = (i_rx_byte == SYNC_B) ? PS_SYNC_B : PS_IDLE;
            PS_SYNC_B: n_parse = (i_rx_byte == STATUS_OK) ? PS_STATUS : PS_IDLE;
            PS_STATUS: n_parse = PS_LOW;
            PS_LOW:    n_parse = PS_HIGH;
            PS_HIGH:   n_parse = PS_CHECK;
            PS_CHECK:  n_parse = check_good ? PS_END : PS_IDLE;
            PS_END:    n_parse = PS_IDLE;
            default:   n_parse = PS_IDLE;
        endcase
    end

    // One restoring division step per cycle. The borrow out of the trial
    // subtraction tells whether the divisor fits.
    assign rem_shift = {r_rem, r_quot[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_divisor};
    assign rem_ge    = ~rem_diff[CNT_W];

    assign prod     = {1'b0, r_quot, 3'b000} + {3'b000, r_quot, 1'b0};
    assign dist_sat = (|prod[PROD_W-1:DIST_W]) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= PS_IDLE;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.take_byte) begin
                r_parse <= n_parse;
                if (r_parse == PS_END && r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + SUM_W'(r_frame_value);
                end
            end
            if (i_cmd.start_div) begin
                r_sum   <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            if (r_parse == PS_STATUS) r_low   <= i_rx_byte;
            if (r_parse == PS_LOW)    r_high  <= i_rx_byte;
            if (r_parse == PS_HIGH)   r_check <= i_rx_byte;
            if (r_parse == PS_CHECK && check_good) begin
                r_frame_value <= {r_high, r_low};
            end
        end
        if (i_cmd.start_div) begin
            r_quot    <= r_sum;
            r_rem     <= '0;
            r_divisor <= r_count;
            r_nonzero <= (r_count != '0);
        end else if (i_cmd.step_div) begin
            r_quot <= {r_quot[SUM_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_dist     <= r_nonzero ? dist_sat : '0;
            r_rd_valid <= r_nonzero;
        end
    end

    assign o_avg_range     = r_dist;
    assign o_reading_valid = r_rd_valid;

endmodule

// File: design/range_frame_parse_average_top.sv
// ----------------------------------------------------------------------------
// range_frame_parse_average_top
// Parses range sensor frames from serial bytes and returns averaged readings.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    i_command, i_rx_byte
//  result    out        o_out_valid / i_out_ready  o_avg_range, o_reading_valid
//
// A byte beat is taken while the block is idle and produces no result. A read
// beat occupies the block: it captures the sum and count and clears the
// accumulators, then steps the restoring divider, then scales by ten,
// saturates and loads the output register. Reset is synchronous and active low.
// Byte beats are still taken while a result waits in the output register; a
// finished read waits for that register to drain.
//
module range_frame_parse_average_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rfpa_pkg::DIST_W-1:0] o_avg_range,
    output logic                        o_reading_valid
);
    import rfpa_pkg::*;

    // Commands from the controller to the datapath.
    t_dp_cmd cmd;

    // The controller owns the handshakes and the divider step count.
    rfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the parser, the running sum and count, the divider
    // and the result register.
    rfpa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rx_byte       (i_rx_byte),
        .o_avg_range     (o_avg_range),
        .o_reading_valid (o_reading_valid)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range frame parser and averager. Byte and read
// beats are pushed through the input channel, and a tracking model of the
// parser and accumulators predicts every reading. Each returned reading is
// checked against the oldest prediction. Idling and stalling vary by phase.
// ----------------------------------------------------------------------------
module tb;
    import rfpa_pkg::*;

    // One beat on the input channel.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_beat;

    // One reading on the result channel.
    typedef struct packed {
        logic [DIST_W-1:0] avg;
        logic              valid;
    } t_reading;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts at a
    // known value, so nothing floats before the first edge.
    // ------------------------------------------------------------------------
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_command  = CMD_BYTE;
    logic [7:0]        in_byte     = 8'h00;
    logic              out_ready   = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [DIST_W-1:0] avg_range;
    logic              reading_valid;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    range_frame_parse_average_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_command       (in_command),
        .i_rx_byte       (in_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_avg_range     (avg_range),
        .o_reading_valid (reading_valid)
    );

    // ------------------------------------------------------------------------
    // Bench state: the beats waiting to be sent, the readings still owed by
    // the block, the idling knobs for the current phase and the tallies.
    // ------------------------------------------------------------------------
    t_beat    queued_beats[$];
    t_reading owed_readings[$];
    t_beat    next_beat;
    t_reading owed;
    int       sender_idle_pct    = 0;
    int       receiver_stall_pct = 0;
    int       beats_planned      = 0;
    int       beats_sent         = 0;
    int       readings_checked   = 0;
    int       empty_reads        = 0;
    int       saturated_reads    = 0;
    int       frames_summed      = 0;
    int       frames_dropped     = 0;
    int       error_count        = 0;

    // Tracking copy of the parser and the accumulators.
    t_parse_state    parser     = PS_IDLE;
    logic [7:0]      frame_lo   = 8'h00;
    logic [7:0]      frame_hi   = 8'h00;
    logic [7:0]      frame_ck   = 8'h00;
    logic [15:0]     frame_val  = 16'h0000;
    logic [SUM_W-1:0] acc_sum   = '0;
    logic [CNT_W-1:0] frame_cnt = '0;

    // The checksum byte that makes a frame good: the two's complement of the
    // low byte of the sum over both sync bytes, the status and the data.
    function automatic logic [7:0] frame_checksum(input logic [7:0] lo,
                                                  input logic [7:0] hi);
        logic [7:0] sum8;
        sum8 = SYNC_A + SYNC_B + STATUS_OK + lo + hi;
        return 8'h00 - sum8;
    endfunction

    // Feeds one accepted beat through the tracking model. A read beat owes a
    // reading: the floor of the average times ten, clipped to 16 bits, and
    // empties the accumulators while leaving the parser where it was.
    task automatic parse_and_accumulate(input logic cmd, input logic [7:0] rx);
        logic [SUM_W-1:0] quotient;
        logic [27:0]      scaled;
        t_reading         r;
        if (cmd == CMD_READ) begin
            if (frame_cnt == '0) begin
                r.avg   = '0;
                r.valid = 1'b0;
                empty_reads++;
            end else begin
                quotient = acc_sum / SUM_W'(frame_cnt);
                scaled   = 28'(quotient) * 28'd10;
                if (scaled > 28'd65535) begin
                    r.avg = 16'hFFFF;
                    saturated_reads++;
                end else begin
                    r.avg = scaled[15:0];
                end
                r.valid = 1'b1;
            end
            owed_readings.push_back(r);
            acc_sum   = '0;
            frame_cnt = '0;
        end else begin
            case (parser)
                PS_IDLE: begin
                    if (rx == SYNC_A) parser = PS_SYNC_A;
                end
                // A wrong second sync byte is dropped outright; it is not
                // looked at again as a possible first sync byte.
                PS_SYNC_A: parser = (rx == SYNC_B) ? PS_SYNC_B : PS_IDLE;
                PS_SYNC_B: parser = (rx == STATUS_OK) ? PS_STATUS : PS_IDLE;
                PS_STATUS: begin
                    frame_lo = rx;
                    parser   = PS_LOW;
                end
                PS_LOW: begin
                    frame_hi = rx;
                    parser   = PS_HIGH;
                end
                PS_HIGH: begin
                    frame_ck = rx;
                    parser   = PS_CHECK;
                end
                // The check is made on the byte after the checksum, whatever
                // its value.
                PS_CHECK: begin
                    if (frame_checksum(frame_lo, frame_hi) == frame_ck) begin
                        frame_val = {frame_hi, frame_lo};
                        parser    = PS_END;
                    end else begin
                        parser = PS_IDLE;
                    end
                end
                // The second trailing byte banks the frame, unless the count
                // is already full, in which case the frame is lost.
                default: begin
                    parser = PS_IDLE;
                    if (frame_cnt != COUNT_MAX) begin
                        frame_cnt = frame_cnt + 1'b1;
                        acc_sum   = acc_sum + SUM_W'(frame_val);
                        frames_summed++;
                    end else begin
                        frames_dropped++;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers. They only fill the queue of beats; the driver below
    // decides when each beat goes out.
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic cmd, input logic [7:0] data);
        t_beat b;
        b.cmd  = cmd;
        b.data = data;
        queued_beats.push_back(b);
        beats_planned++;
    endtask

    // Trailing bytes are ignored by the parser, so a sync byte there is a
    // good way to catch a parser that looks at them.
    function automatic logic [7:0] trailing_byte();
        return ($urandom_range(3) == 0) ? SYNC_A : 8'($urandom);
    endfunction

    // A whole frame with its two trailing bytes. A nonzero ck_flip spoils the
    // checksum. A read beat can be slipped in before byte read_at (0 to 7).
    task automatic push_frame(input logic [15:0] value, input logic [7:0] ck_flip,
                              input logic [7:0] trail_a, input logic [7:0] trail_b,
                              input int read_at);
        logic [7:0] frame_bytes [8];
        frame_bytes = '{SYNC_A, SYNC_B, STATUS_OK, value[7:0], value[15:8],
                        frame_checksum(value[7:0], value[15:8]) ^ ck_flip,
                        trail_a, trail_b};
        for (int i = 0; i < 8; i++) begin
            if (i == read_at) queue_beat(CMD_READ, 8'($urandom));
            queue_beat(CMD_BYTE, frame_bytes[i]);
        end
    endtask

    // One random unit of traffic. Good frames dominate so that the averaging
    // path is well exercised; the rest is broken frames, line noise and reads.
    task automatic add_random_unit();
        int          pick;
        int          read_at;
        logic [15:0] value;
        logic [7:0]  bad;
        pick = $urandom_range(99);
        if (pick < 55) begin
            case ($urandom_range(7))
                0:       value = 16'hFFFF;
                1:       value = 16'h0000;
                2, 3:    value = 16'($urandom_range(6553));
                default: value = 16'($urandom);
            endcase
            read_at = ($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1;
            push_frame(value, 8'h00, trailing_byte(), trailing_byte(), read_at);
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0: begin
                    // Second sync byte wrong, often a repeated first sync.
                    queue_beat(CMD_BYTE, SYNC_A);
                    do bad = $urandom_range(1) ? SYNC_A : 8'($urandom);
                    while (bad == SYNC_B);
                    queue_beat(CMD_BYTE, bad);
                end
                1: begin
                    queue_beat(CMD_BYTE, SYNC_A);
                    queue_beat(CMD_BYTE, SYNC_B);
                    do bad = 8'($urandom);
                    while (bad == STATUS_OK);
                    queue_beat(CMD_BYTE, bad);
                end
                2: push_frame(16'($urandom), 8'($urandom_range(1, 255)),
                              trailing_byte(), trailing_byte(), -1);
                default: begin
                    // Cut short: whatever follows lands in the data slots.
                    queue_beat(CMD_BYTE, SYNC_A);
                    queue_beat(CMD_BYTE, SYNC_B);
                    queue_beat(CMD_BYTE, STATUS_OK);
                    repeat ($urandom_range(2)) queue_beat(CMD_BYTE, 8'($urandom));
                end
            endcase
        end else if (pick < 80) begin
            queue_beat(CMD_BYTE, 8'($urandom));
        end else begin
            queue_beat(CMD_READ, 8'($urandom));
        end
    endtask

    // Holds the sender back until every queued beat has gone and every owed
    // reading has come home. Sampling on the falling edge keeps the queue
    // updates clear of the rising-edge processes.
    task automatic wait_drained();
        do @(negedge clk);
        while (queued_beats.size() != 0 || in_valid || owed_readings.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver. A new beat is offered only once the previous one has been taken
    // (or nothing was on offer), so valid and payload hold steady while the
    // block is busy. In idle cycles the payload carries junk.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (queued_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_beat   = queued_beats.pop_front();
                in_valid   <= 1'b1;
                in_command <= next_beat.cmd;
                in_byte    <= next_beat.data;
            end else begin
                in_valid   <= 1'b0;
                in_command <= 1'($urandom);
                in_byte    <= 8'($urandom);
            end
        end
    end

    // Receiver: ready is redrawn every cycle from the phase's stall rate.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Accepted input beats drive the tracking model; accepted result
    // beats are checked field by field against the oldest owed reading.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                beats_sent++;
                parse_and_accumulate(in_command, in_byte);
            end
            if (out_valid && out_ready) begin
                if (owed_readings.size() == 0) begin
                    $error("unexpected reading: avg_range %0d, reading_valid %0b",
                           avg_range, reading_valid);
                    error_count++;
                end else begin
                    owed = owed_readings.pop_front();
                    readings_checked++;
                    if (avg_range !== owed.avg) begin
                        $error("avg_range: expected %0d, got %0d", owed.avg, avg_range);
                        error_count++;
                    end
                    if (reading_valid !== owed.valid) begin
                        $error("reading_valid: expected %0b, got %0b",
                               owed.valid, reading_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        int target;
        int cut;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. A read with nothing banked; a frame at full scale
        // with a read slipped in before its trailing bytes, which are both
        // sync bytes; a read that must clip at 65535; a repeated first sync;
        // a bad status byte of zero; and a frame with a spoilt checksum.
        queue_beat(CMD_READ, 8'h00);
        push_frame(16'hFFFF, 8'h00, SYNC_A, SYNC_A, 6);
        queue_beat(CMD_READ, 8'hFF);
        queue_beat(CMD_BYTE, SYNC_A);
        queue_beat(CMD_BYTE, SYNC_A);
        queue_beat(CMD_BYTE, SYNC_B);
        queue_beat(CMD_BYTE, STATUS_OK);
        queue_beat(CMD_BYTE, SYNC_A);
        queue_beat(CMD_BYTE, SYNC_B);
        queue_beat(CMD_BYTE, 8'h00);
        push_frame(16'h0000, 8'h01, 8'hFF, 8'h00, -1);
        wait_drained();

        // Random traffic in four idling phases: none, a lazy sender, a lazy
        // receiver, then a little of both. The drain between phases also
        // covers the sender pausing until the block has caught up.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 72;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 72;
                end
                default: begin
                    sender_idle_pct    = 12;
                    receiver_stall_pct = 12;
                end
            endcase
            target = beats_planned + 100;
            while (beats_planned < target) add_random_unit();
            wait_drained();
        end

        // Fill the frame count to the top and past it, then read twice: the
        // second read must find the accumulators empty. Small values keep the
        // average clear of clipping so the sum itself is checked; the frames
        // past the limit are at full scale and would skew it if counted.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cut = int'(COUNT_MAX);
        for (int f = 0; f < cut + 2; f++) begin
            push_frame((f < cut) ? 16'($urandom_range(6553)) : 16'hFFFF, 8'h00,
                       trailing_byte(), trailing_byte(), -1);
        end
        queue_beat(CMD_READ, 8'($urandom));
        queue_beat(CMD_READ, 8'($urandom));
        wait_drained();

        // This tail gives time to catch a stray reading after the last one owed.
        repeat (40) @(posedge clk);

        $display("summary: %0d beats sent, %0d readings checked (%0d empty, %0d clipped)",
                 beats_sent, readings_checked, empty_reads, saturated_reads);
        $display("summary: %0d frames summed, %0d lost to a full count",
                 frames_summed, frames_dropped);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog. The slowest correct run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/rfpa_pkg.sv
design/rfpa_ctrl.sv
design/rfpa_dp.sv
design/range_frame_parse_average_top.sv
sim/tb.sv
